[rtl/core/amgt_pkg.sv]
// shared types and codes for the adjacency matrix graph traversal block
package amgt_pkg;

  localparam int unsigned NODE_W = 5;
  localparam int unsigned CFG_W  = 6;

  typedef enum logic [1:0] {
    KIND_EDGE = 2'd0,
    KIND_BFS  = 2'd1,
    KIND_DFS  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_ROW_WAIT,
    ST_SCAN,
    ST_POP_WAIT,
    ST_FINISH,
    ST_ERROR
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } in_beat_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    logic              error;
  } out_beat_t;

endpackage

[rtl/core/amgt_adj_mem.sv]
// adjacency row memory with per-row valid bits so unwritten rows read as empty
module amgt_adj_mem #(
  parameter int unsigned ROWS  = 32,
  parameter int unsigned IDX_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [ROWS-1:0]  wr_data_i,
  output logic [ROWS-1:0]  rd_data_o
);

  logic [ROWS-1:0] mem_q [ROWS];
  logic [ROWS-1:0] row_vld_q;
  logic [ROWS-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en_i) begin
      row_vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= row_vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/adjacency_matrix_graph_traversal.sv]
// top level: edge store and breadth-first / depth-first traversal sequencer
// edge beat: row read in ST_IDLE, rewritten in ST_EDGE_WR; a bad start emits via ST_ERROR
// traversal: the scan tests one neighbor bit per cycle over the active nodes, a depth-first
//   hit waiting for a free output register; rows and queue/stack entries are read registered
// one beat at a time; the next beat is taken once the last result is in the output register
// reset: adjacency rows read as empty through row valid bits (no clearing pass), count zero
module adjacency_matrix_graph_traversal #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [amgt_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  amgt_pkg::in_beat_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output amgt_pkg::out_beat_t       out_data_o
);
  import amgt_pkg::*;

  localparam int unsigned ROWS  = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int unsigned IDX_W = $clog2(ROWS);
  localparam int unsigned CNT_W = $clog2(ROWS + 1);
  localparam int unsigned WS_W  = IDX_W + CNT_W;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  node_count_q;
  logic              dfs_q, dfs_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  depth_q, depth_d;
  logic [ROWS-1:0]   visited_q, visited_d;
  logic              pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]  pend_q, pend_d;
  logic [IDX_W-1:0]  edge_row_q, edge_row_d;
  logic [IDX_W-1:0]  edge_to_q, edge_to_d;
  logic              out_vld_q, out_vld_d;
  out_beat_t         out_q, out_d;

  logic              adj_rd_en;
  logic [IDX_W-1:0]  adj_rd_addr;
  logic              adj_wr_en;
  logic [IDX_W-1:0]  adj_wr_addr;
  logic [ROWS-1:0]   adj_wr_data;
  logic [ROWS-1:0]   adj_row;

  logic [WS_W-1:0]   ws_mem_q [ROWS];
  logic [WS_W-1:0]   ws_rdata_q;
  logic              ws_we;
  logic [IDX_W-1:0]  ws_waddr;
  logic [WS_W-1:0]   ws_wdata;
  logic              ws_re;
  logic [IDX_W-1:0]  ws_raddr;

  logic [CNT_W-1:0]  cnt;
  logic              emit_ok;
  logic              hit;
  logic [IDX_W-1:0]  idx_node;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  depth_dec1;
  logic [CNT_W-1:0]  depth_dec2;
  logic [IDX_W-1:0]  ws_node;
  logic [CNT_W-1:0]  ws_next;

  amgt_adj_mem #(
    .ROWS  (ROWS),
    .IDX_W (IDX_W)
  ) u_adj_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (adj_rd_en),
    .rd_addr_i (adj_rd_addr),
    .wr_en_i   (adj_wr_en),
    .wr_addr_i (adj_wr_addr),
    .wr_data_i (adj_wr_data),
    .rd_data_o (adj_row)
  );

  // queue for breadth-first, return stack for depth-first
  always_ff @(posedge clk_i) begin
    if (ws_we) begin
      ws_mem_q[ws_waddr] <= ws_wdata;
    end
    if (ws_re) begin
      ws_rdata_q <= ws_mem_q[ws_raddr];
    end
  end

  assign cnt = (7'(node_count_q) > 7'(ROWS)) ? CNT_W'(ROWS) : CNT_W'(node_count_q);
  assign emit_ok    = !out_vld_q || out_ready_i;
  assign idx_node   = idx_q[IDX_W-1:0];
  assign idx_inc    = idx_q + CNT_W'(1);
  assign depth_dec1 = depth_q - CNT_W'(1);
  assign depth_dec2 = depth_q - CNT_W'(2);
  assign hit        = adj_row[idx_node] && !visited_q[idx_node];
  assign ws_node    = ws_rdata_q[WS_W-1 -: IDX_W];
  assign ws_next    = ws_rdata_q[CNT_W-1:0];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      depth_q      <= '0;
      visited_q    <= '0;
      pend_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      dfs_q        <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      depth_q    <= depth_d;
      visited_q  <= visited_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      dfs_q      <= dfs_d;
      if (cfg_valid_i) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    idx_q      <= idx_d;
    pend_q     <= pend_d;
    edge_row_q <= edge_row_d;
    edge_to_q  <= edge_to_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    dfs_d       = dfs_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    head_d      = head_q;
    tail_d      = tail_q;
    depth_d     = depth_q;
    visited_d   = visited_q;
    pend_vld_d  = pend_vld_q;
    pend_d      = pend_q;
    edge_row_d  = edge_row_q;
    edge_to_d   = edge_to_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;
    adj_rd_en   = 1'b0;
    adj_rd_addr = cur_q;
    adj_wr_en   = 1'b0;
    adj_wr_addr = edge_row_q;
    adj_wr_data = adj_row | (ROWS'(1) << edge_to_q);
    ws_we       = 1'b0;
    ws_waddr    = tail_q[IDX_W-1:0];
    ws_wdata    = {idx_node, CNT_W'(0)};
    ws_re       = 1'b0;
    ws_raddr    = head_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.kind)
            KIND_EDGE: begin
              if (6'(in_data_i.from_node) < 6'(ROWS) && 6'(in_data_i.to_node) < 6'(ROWS)) begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = in_data_i.from_node[IDX_W-1:0];
                edge_row_d  = in_data_i.from_node[IDX_W-1:0];
                edge_to_d   = in_data_i.to_node[IDX_W-1:0];
                state_d     = ST_EDGE_WR;
              end
            end
            KIND_BFS, KIND_DFS: begin
              if (6'(in_data_i.from_node) >= 6'(cnt)) begin
                state_d = ST_ERROR;
              end else begin
                dfs_d      = (in_data_i.kind == KIND_DFS);
                cur_d      = in_data_i.from_node[IDX_W-1:0];
                idx_d      = '0;
                head_d     = CNT_W'(1);
                tail_d     = CNT_W'(1);
                depth_d    = CNT_W'(1);
                visited_d  = '0;
                visited_d[in_data_i.from_node[IDX_W-1:0]] = 1'b1;
                pend_d     = in_data_i.from_node[IDX_W-1:0];
                pend_vld_d = 1'b1;
                adj_rd_en   = 1'b1;
                adj_rd_addr = in_data_i.from_node[IDX_W-1:0];
                state_d     = ST_ROW_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EDGE_WR: begin
        adj_wr_en = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_ROW_WAIT: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_q == cnt) begin
          if (dfs_q) begin
            if (depth_q == CNT_W'(1)) begin
              state_d = ST_FINISH;
            end else begin
              depth_d  = depth_dec1;
              ws_re    = 1'b1;
              ws_raddr = depth_dec2[IDX_W-1:0];
              state_d  = ST_POP_WAIT;
            end
          end else if (head_q == tail_q) begin
            state_d = ST_FINISH;
          end else begin
            ws_re    = 1'b1;
            ws_raddr = head_q[IDX_W-1:0];
            head_d   = head_q + CNT_W'(1);
            state_d  = ST_POP_WAIT;
          end
        end else if (hit) begin
          if (dfs_q) begin
            if (emit_ok) begin
              ws_we      = 1'b1;
              ws_waddr   = depth_dec1[IDX_W-1:0];
              ws_wdata   = {cur_q, idx_inc};
              depth_d    = depth_q + CNT_W'(1);
              visited_d[idx_node] = 1'b1;
              cur_d      = idx_node;
              idx_d      = '0;
              if (pend_vld_q) begin
                out_d     = '{node: NODE_W'(pend_q), last: 1'b0, error: 1'b0};
                out_vld_d = 1'b1;
              end
              pend_d      = idx_node;
              pend_vld_d  = 1'b1;
              adj_rd_en   = 1'b1;
              adj_rd_addr = idx_node;
              state_d     = ST_ROW_WAIT;
            end
          end else begin
            visited_d[idx_node] = 1'b1;
            ws_we    = 1'b1;
            ws_waddr = tail_q[IDX_W-1:0];
            ws_wdata = {idx_node, CNT_W'(0)};
            tail_d   = tail_q + CNT_W'(1);
            idx_d    = idx_inc;
          end
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_POP_WAIT: begin
        if (dfs_q) begin
          cur_d       = ws_node;
          idx_d       = ws_next;
          adj_rd_en   = 1'b1;
          adj_rd_addr = ws_node;
          state_d     = ST_ROW_WAIT;
        end else if (emit_ok) begin
          cur_d = ws_node;
          idx_d = '0;
          if (pend_vld_q) begin
            out_d     = '{node: NODE_W'(pend_q), last: 1'b0, error: 1'b0};
            out_vld_d = 1'b1;
          end
          pend_d      = ws_node;
          pend_vld_d  = 1'b1;
          adj_rd_en   = 1'b1;
          adj_rd_addr = ws_node;
          state_d     = ST_ROW_WAIT;
        end
      end
      ST_FINISH: begin
        if (emit_ok) begin
          out_d      = '{node: NODE_W'(pend_q), last: 1'b1, error: 1'b0};
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (emit_ok) begin
          out_d     = '{node: '0, last: 1'b1, error: 1'b1};
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
